>>> design/lmsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lmsd_pkg;

   // signed coordinate arithmetic, wide enough for any supported frame size
   localparam int COORD_W = 16;
   localparam int PIX_W   = 16;

   localparam logic [PIX_W-1:0] BRIGHT_LEVEL = 16'd32512;
   localparam logic [PIX_W-1:0] DARK_LEVEL   = 16'd256;

   // register indexes on the configuration port
   localparam logic [2:0] REG_THRESHOLD  = 3'd0;
   localparam logic [2:0] REG_SUBTRACT   = 3'd1;
   localparam logic [2:0] REG_COPY       = 3'd2;
   localparam logic [2:0] REG_WIDTH      = 3'd3;
   localparam logic [2:0] REG_HEIGHT     = 3'd4;
   localparam logic [2:0] REG_RESTRICT   = 3'd5;
   localparam logic [2:0] REG_SEARCH_X   = 3'd6;
   localparam logic [2:0] REG_SEARCH_Y   = 3'd7;

   typedef enum logic [1:0] {
      REC_DETECT  = 2'd0,
      REC_PIXEL   = 2'd1,
      REC_SUMMARY = 2'd2
   } rec_kind_type;

   typedef struct packed {
      logic [15:0] threshold;
      logic        subtract_background;
      logic        copy_regions;
      logic [10:0] image_width;
      logic [10:0] image_height;
      logic        restrict_search;
      logic [9:0]  search_x;
      logic [9:0]  search_y;
   } cfg_type;

   // one queued result: a detection or a frame summary
   typedef struct packed {
      rec_kind_type kind;
      logic [9:0]   idx;
      logic [9:0]   x;
      logic [9:0]   y;
      logic [15:0]  frame;
      logic [10:0]  count;
      logic         bright;
      logic         dark;
      logic         limit;
      logic         copy;
      logic         last;
   } job_type;

   typedef struct packed {
      logic queue_empty;
      logic copy_busy;
   } back_status_type;

endpackage

`default_nettype wire

>>> design/lmsd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lmsd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/lmsd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lmsd_front
   import lmsd_pkg::*;
#(
   parameter int WINDOW_RADIUS = 3,
   parameter int MAX_WIDTH     = 1024,
   parameter int MAX_HEIGHT    = 1024,
   parameter int MAX_FOUND     = 1024
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cfg_type         cfg,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic [15:0]     req_pixel,
   input  wire logic [15:0]     req_frame_index,
   input  wire logic            req_frame_start,
   output logic                 push_valid,
   output job_type              push_job,
   input  wire logic            queue_full,
   input  wire back_status_type back_status,
   output logic [PIX_W-1:0]     window [(2*WINDOW_RADIUS+1)*(2*WINDOW_RADIUS+1)]
);

   localparam int SIDE = 2 * WINDOW_RADIUS + 1;
   localparam int SPAN = 2 * WINDOW_RADIUS;
   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int YW   = $clog2(MAX_HEIGHT);
   localparam int SW   = (SPAN > 1) ? $clog2(SPAN) : 1;
   localparam int RW   = $clog2(SIDE);
   localparam int FW   = $clog2(MAX_FOUND + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_DECIDE,
      ST_END
   } state_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   state_type         state_ff;
   logic [XW-1:0]     col_ff;
   logic [YW-1:0]     line_ff;
   logic [SW-1:0]     ymod_ff;
   logic [PIX_W-1:0]  pix_ff;
   logic [15:0]       frame_ff;
   logic              bright_ff;
   logic              dark_ff;
   logic [FW-1:0]     found_ff;
   logic [RW-1:0]     row_ff;
   logic [PIX_W-1:0]  mx_ff;
   logic [PIX_W-1:0]  mn_ff;
   logic              sb_ff;
   logic              sd_ff;
   logic              copy_hold_ff;
   logic [PIX_W-1:0]  win_ff [SIDE][SIDE];

   logic                   accept;
   logic [XW-1:0]          rd_addr;
   logic [SPAN*PIX_W-1:0]  rd_data;
   logic [SPAN*PIX_W-1:0]  wr_data;
   logic                   wr_en;

   coord_type w_eff, h_eff, xl, xh, yl, yh, cx, cy;
   logic      candidate, frame_end;
   logic [PIX_W-1:0] mx_in, mn_in;
   logic      sb_in, sd_in;
   logic [PIX_W-1:0] ctr;
   logic signed [PIX_W:0] diff;
   logic      detect;
   logic [FW-1:0] found_inc;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || copy_hold_ff;

   // line store: one word per column holding every stored line
   assign rd_addr = req_frame_start ? '0 : col_ff;
   assign wr_en   = (state_ff == ST_LOAD);

   always_comb begin
      wr_data = rd_data;
      for (int s = 0; s < SPAN; s++) begin
         if (ymod_ff == SW'(s)) begin
            wr_data[s*PIX_W +: PIX_W] = pix_ff;
         end
      end
   end

   lmsd_ram #(
      .WIDTH(SPAN * PIX_W),
      .DEPTH(MAX_WIDTH)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(col_ff),
      .wr_data(wr_data),
      .rd_en  (accept),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // clamped frame size and the search box
   always_comb begin
      coord_type wv, hv, sx, sy, rad;
      wv  = coord_type'(COORD_W'(cfg.image_width));
      hv  = coord_type'(COORD_W'(cfg.image_height));
      sx  = coord_type'(COORD_W'(cfg.search_x));
      sy  = coord_type'(COORD_W'(cfg.search_y));
      rad = coord_type'(WINDOW_RADIUS);
      w_eff = (wv < coord_type'(SIDE)) ? coord_type'(SIDE) :
              (wv > coord_type'(MAX_WIDTH)) ? coord_type'(MAX_WIDTH) : wv;
      h_eff = (hv < coord_type'(SIDE)) ? coord_type'(SIDE) :
              (hv > coord_type'(MAX_HEIGHT)) ? coord_type'(MAX_HEIGHT) : hv;
      xl = cfg.restrict_search ? sx - rad : rad;
      xh = cfg.restrict_search ? sx + rad + coord_type'(1) : w_eff - rad;
      yl = cfg.restrict_search ? sy - rad : rad;
      yh = cfg.restrict_search ? sy + rad + coord_type'(1) : h_eff - rad;
      if (xl < rad) xl = rad;
      if (xh > w_eff - rad) xh = w_eff - rad;
      if (yl < rad) yl = rad;
      if (yh > h_eff - rad) yh = h_eff - rad;
      cx = coord_type'(COORD_W'(col_ff)) - rad;
      cy = coord_type'(COORD_W'(line_ff)) - rad;
      candidate = (col_ff >= XW'(SPAN)) && (line_ff >= YW'(SPAN)) &&
                  (found_ff < FW'(MAX_FOUND)) &&
                  (cx >= xl) && (cx < xh) && (cy >= yl) && (cy < yh);
      frame_end = (coord_type'(COORD_W'(col_ff)) + coord_type'(1) >= w_eff) &&
                  (coord_type'(COORD_W'(line_ff)) + coord_type'(1) >= h_eff);
   end

   // one window row per cycle into the running extremes and flags
   always_comb begin
      logic [PIX_W-1:0] v;
      mx_in = mx_ff;
      mn_in = mn_ff;
      sb_in = sb_ff;
      sd_in = sd_ff;
      for (int c = 0; c < SIDE; c++) begin
         v = win_ff[row_ff][c];
         if (v > BRIGHT_LEVEL) sb_in = 1'b1;
         if (!(v < DARK_LEVEL)) sd_in = 1'b0;
         if (!(row_ff == RW'(WINDOW_RADIUS) && c == WINDOW_RADIUS)) begin
            if (v > mx_in) mx_in = v;
            if (v < mn_in) mn_in = v;
         end
      end
   end

   // detection decision on the center
   assign ctr       = win_ff[WINDOW_RADIUS][WINDOW_RADIUS];
   assign diff      = cfg.subtract_background ?
                      $signed({1'b0, ctr}) - $signed({1'b0, mn_ff}) :
                      $signed({1'b0, ctr});
   assign detect    = (ctr >= mx_ff) && (diff > $signed({1'b0, cfg.threshold}));
   assign found_inc = found_ff + FW'(1);

   // queue pushes
   always_comb begin
      push_valid = 1'b0;
      push_job   = '0;
      push_job.frame  = frame_ff;
      push_job.bright = bright_ff;
      push_job.dark   = dark_ff;
      if (state_ff == ST_DECIDE && detect) begin
         push_valid     = !queue_full;
         push_job.kind  = REC_DETECT;
         push_job.idx   = found_ff[9:0];
         push_job.x     = 10'(cx);
         push_job.y     = 10'(cy);
         push_job.count = 11'(found_inc);
         push_job.limit = (found_inc >= FW'(MAX_FOUND));
         push_job.copy  = cfg.copy_regions;
         push_job.last  = !frame_end;
      end else if (state_ff == ST_END && frame_end) begin
         push_valid     = !queue_full;
         push_job.kind  = REC_SUMMARY;
         push_job.count = 11'(found_ff);
         push_job.limit = (found_ff >= FW'(MAX_FOUND));
         push_job.last  = 1'b1;
      end
   end

   // control sequencer with window and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         line_ff      <= '0;
         ymod_ff      <= '0;
         bright_ff    <= 1'b0;
         dark_ff      <= 1'b1;
         found_ff     <= '0;
         row_ff       <= '0;
         copy_hold_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (copy_hold_ff && back_status.queue_empty && !back_status.copy_busy) begin
                  copy_hold_ff <= 1'b0;
               end
               if (accept) begin
                  pix_ff   <= req_pixel;
                  frame_ff <= req_frame_index;
                  if (req_frame_start) begin
                     col_ff    <= '0;
                     line_ff   <= '0;
                     ymod_ff   <= '0;
                     bright_ff <= 1'b0;
                     dark_ff   <= 1'b1;
                  end
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               for (int r = 0; r < SIDE; r++) begin
                  for (int c = 0; c < SIDE - 1; c++) begin
                     win_ff[r][c] <= win_ff[r][c+1];
                  end
               end
               // stored line slot of each window row, wrapped once at the span
               for (int r = 0; r < SPAN; r++) begin
                  for (int s = 0; s < SPAN; s++) begin
                     if ((32'(ymod_ff) + 32'(r) == 32'(s)) ||
                         (32'(ymod_ff) + 32'(r) == 32'(s + SPAN))) begin
                        win_ff[r][SIDE-1] <= rd_data[s*PIX_W +: PIX_W];
                     end
                  end
               end
               win_ff[SPAN][SIDE-1] <= pix_ff;
               row_ff <= '0;
               mx_ff  <= '0;
               mn_ff  <= '1;
               sb_ff  <= bright_ff;
               sd_ff  <= dark_ff;
               state_ff <= candidate ? ST_SCAN : ST_END;
            end
            ST_SCAN: begin
               mx_ff  <= mx_in;
               mn_ff  <= mn_in;
               sb_ff  <= sb_in;
               sd_ff  <= sd_in;
               row_ff <= row_ff + RW'(1);
               if (row_ff == RW'(SIDE - 1)) begin
                  bright_ff <= sb_in;
                  dark_ff   <= sd_in;
                  state_ff  <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (!detect) begin
                  state_ff <= ST_END;
               end else if (!queue_full) begin
                  found_ff     <= found_inc;
                  copy_hold_ff <= cfg.copy_regions;
                  state_ff     <= ST_END;
               end
            end
            ST_END: begin
               if (!(frame_end && queue_full)) begin
                  if (coord_type'(COORD_W'(col_ff)) + coord_type'(1) >= w_eff) begin
                     col_ff <= '0;
                     if (frame_end) begin
                        line_ff   <= '0;
                        ymod_ff   <= '0;
                        bright_ff <= 1'b0;
                        dark_ff   <= 1'b1;
                     end else begin
                        line_ff <= line_ff + YW'(1);
                        ymod_ff <= (ymod_ff == SW'(SPAN - 1)) ? '0 : ymod_ff + SW'(1);
                     end
                  end else begin
                     col_ff <= col_ff + XW'(1);
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   for (genvar r = 0; r < SIDE; r++) begin : g_row
      for (genvar c = 0; c < SIDE; c++) begin : g_col
         assign window[r*SIDE+c] = win_ff[r][c];
      end
   end

endmodule

`default_nettype wire

>>> design/lmsd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module lmsd_queue
   import lmsd_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output job_type      head,
   output logic         empty
);

   localparam int AW = $clog2(DEPTH);

   job_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff;
   logic [AW-1:0]   rd_ptr_ff;
   logic [AW:0]     count_ff;

   assign full  = (count_ff == (AW+1)'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // pointers wrap at the depth
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            mem_ff[wr_ptr_ff] <= push_job;
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         if (push_valid && !pop) begin
            count_ff <= count_ff + (AW+1)'(1);
         end else if (pop && !push_valid) begin
            count_ff <= count_ff - (AW+1)'(1);
         end
      end
   end

endmodule

`default_nettype wire

>>> design/lmsd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lmsd_back
   import lmsd_pkg::*;
#(
   parameter int WINDOW_RADIUS = 3
) (
   input  wire logic        clock,
   input  wire logic        reset,
   output logic             pop,
   input  wire job_type     head,
   input  wire logic        empty,
   input  wire logic [PIX_W-1:0] window [(2*WINDOW_RADIUS+1)*(2*WINDOW_RADIUS+1)],
   output back_status_type  status,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_record_kind,
   output logic [9:0]       rsp_detection_index,
   output logic [9:0]       rsp_pos_x,
   output logic [9:0]       rsp_pos_y,
   output logic [15:0]      rsp_frame_out,
   output logic [15:0]      rsp_pixel_value,
   output logic [10:0]      rsp_detection_count,
   output logic             rsp_bright_warning,
   output logic             rsp_dark_warning,
   output logic             rsp_limit_reached,
   output logic             rsp_last
);

   localparam int SIDE = 2 * WINDOW_RADIUS + 1;
   localparam int NPIX = SIDE * SIDE;
   localparam int RW   = $clog2(SIDE);
   localparam int PW   = $clog2(NPIX);

   job_type        cur_ff;
   logic           busy_ff;
   logic [RW-1:0]  r_ff;
   logic [RW-1:0]  c_ff;
   logic [PW-1:0]  p_ff;
   logic           valid_ff;
   rec_kind_type   kind_ff;
   logic [9:0]     idx_ff, x_ff, y_ff;
   logic [15:0]    frame_ff, value_ff;
   logic [10:0]    count_ff;
   logic           bright_ff, dark_ff, limit_ff, last_ff;

   logic can_load;

   assign can_load = !valid_ff || !rsp_stall;
   assign pop      = can_load && !busy_ff && !empty;

   assign status.queue_empty = empty;
   assign status.copy_busy   = busy_ff;

   // output register fed from the queue head or from the window copy
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         busy_ff  <= 1'b0;
         r_ff     <= '0;
         c_ff     <= '0;
         p_ff     <= '0;
      end else if (can_load) begin
         if (busy_ff) begin
            valid_ff  <= 1'b1;
            kind_ff   <= REC_PIXEL;
            idx_ff    <= cur_ff.idx;
            x_ff      <= 10'(c_ff);
            y_ff      <= 10'(r_ff);
            frame_ff  <= cur_ff.frame;
            value_ff  <= window[p_ff];
            count_ff  <= cur_ff.count;
            bright_ff <= cur_ff.bright;
            dark_ff   <= cur_ff.dark;
            limit_ff  <= cur_ff.limit;
            last_ff   <= cur_ff.last && (p_ff == PW'(NPIX - 1));
            p_ff      <= p_ff + PW'(1);
            if (c_ff == RW'(SIDE - 1)) begin
               c_ff <= '0;
               r_ff <= r_ff + RW'(1);
            end else begin
               c_ff <= c_ff + RW'(1);
            end
            if (p_ff == PW'(NPIX - 1)) begin
               busy_ff <= 1'b0;
            end
         end else if (!empty) begin
            valid_ff  <= 1'b1;
            cur_ff    <= head;
            kind_ff   <= head.kind;
            idx_ff    <= head.idx;
            x_ff      <= head.x;
            y_ff      <= head.y;
            frame_ff  <= head.frame;
            value_ff  <= '0;
            count_ff  <= head.count;
            bright_ff <= head.bright;
            dark_ff   <= head.dark;
            limit_ff  <= head.limit;
            last_ff   <= head.last && !head.copy;
            if (head.kind == REC_DETECT && head.copy) begin
               busy_ff <= 1'b1;
               r_ff    <= '0;
               c_ff    <= '0;
               p_ff    <= '0;
            end
         end else begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_record_kind     = kind_ff;
   assign rsp_detection_index = idx_ff;
   assign rsp_pos_x           = x_ff;
   assign rsp_pos_y           = y_ff;
   assign rsp_frame_out       = frame_ff;
   assign rsp_pixel_value     = value_ff;
   assign rsp_detection_count = count_ff;
   assign rsp_bright_warning  = bright_ff;
   assign rsp_dark_warning    = dark_ff;
   assign rsp_limit_reached   = limit_ff;
   assign rsp_last            = last_ff;

endmodule

`default_nettype wire

>>> design/local_maximum_spot_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: a pixel whose center is not examined goes from load straight to the end state, where a
// summary (if any) is pushed; an examined center adds a row-by-row scan of the window and a decision.
// The front sequencer takes no new pixel before it is through with the last one; a window copy
// holds the next pixel until its records drain.
// Reset: synchronous, active high; counters, flags, queue and output valid cleared, line store
// left unwritten.

module local_maximum_spot_detector
   import lmsd_pkg::*;
#(
   parameter int WINDOW_RADIUS = 3,
   parameter int MAX_WIDTH     = 1024,
   parameter int MAX_HEIGHT    = 1024,
   parameter int MAX_FOUND     = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_pixel,
   input  wire logic [15:0] req_frame_index,
   input  wire logic        req_frame_start,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_record_kind,
   output logic [9:0]       rsp_detection_index,
   output logic [9:0]       rsp_pos_x,
   output logic [9:0]       rsp_pos_y,
   output logic [15:0]      rsp_frame_out,
   output logic [15:0]      rsp_pixel_value,
   output logic [10:0]      rsp_detection_count,
   output logic             rsp_bright_warning,
   output logic             rsp_dark_warning,
   output logic             rsp_limit_reached,
   output logic             rsp_last
);

   localparam int SIDE = 2 * WINDOW_RADIUS + 1;

   cfg_type         cfg_ff;
   logic            queue_full, queue_empty, pop, push_valid;
   job_type         push_job, head;
   back_status_type back_status;
   logic [PIX_W-1:0] window [SIDE*SIDE];
   logic [2:0]      reg_index;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];

   // register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold           <= '0;
         cfg_ff.subtract_background <= 1'b1;
         cfg_ff.copy_regions        <= 1'b0;
         cfg_ff.image_width         <= 11'd1024;
         cfg_ff.image_height        <= 11'd1024;
         cfg_ff.restrict_search     <= 1'b0;
         cfg_ff.search_x            <= '0;
         cfg_ff.search_y            <= '0;
      end else if (psel && penable && pwrite && pready) begin
         unique case (reg_index)
            REG_THRESHOLD: cfg_ff.threshold           <= pwdata[15:0];
            REG_SUBTRACT:  cfg_ff.subtract_background <= pwdata[0];
            REG_COPY:      cfg_ff.copy_regions        <= pwdata[0];
            REG_WIDTH:     cfg_ff.image_width         <= pwdata[10:0];
            REG_HEIGHT:    cfg_ff.image_height        <= pwdata[10:0];
            REG_RESTRICT:  cfg_ff.restrict_search     <= pwdata[0];
            REG_SEARCH_X:  cfg_ff.search_x            <= pwdata[9:0];
            REG_SEARCH_Y:  cfg_ff.search_y            <= pwdata[9:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (reg_index)
         REG_THRESHOLD: prdata = 32'(cfg_ff.threshold);
         REG_SUBTRACT:  prdata = 32'(cfg_ff.subtract_background);
         REG_COPY:      prdata = 32'(cfg_ff.copy_regions);
         REG_WIDTH:     prdata = 32'(cfg_ff.image_width);
         REG_HEIGHT:    prdata = 32'(cfg_ff.image_height);
         REG_RESTRICT:  prdata = 32'(cfg_ff.restrict_search);
         REG_SEARCH_X:  prdata = 32'(cfg_ff.search_x);
         REG_SEARCH_Y:  prdata = 32'(cfg_ff.search_y);
         default:       prdata = '0;
      endcase
   end

   lmsd_front #(
      .WINDOW_RADIUS(WINDOW_RADIUS),
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_HEIGHT   (MAX_HEIGHT),
      .MAX_FOUND    (MAX_FOUND)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel      (req_pixel),
      .req_frame_index(req_frame_index),
      .req_frame_start(req_frame_start),
      .push_valid     (push_valid),
      .push_job       (push_job),
      .queue_full     (queue_full),
      .back_status    (back_status),
      .window         (window)
   );

   lmsd_queue #(
      .DEPTH(4)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .head      (head),
      .empty     (queue_empty)
   );

   lmsd_back #(
      .WINDOW_RADIUS(WINDOW_RADIUS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .pop                (pop),
      .head               (head),
      .empty              (queue_empty),
      .window             (window),
      .status             (back_status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_record_kind    (rsp_record_kind),
      .rsp_detection_index(rsp_detection_index),
      .rsp_pos_x          (rsp_pos_x),
      .rsp_pos_y          (rsp_pos_y),
      .rsp_frame_out      (rsp_frame_out),
      .rsp_pixel_value    (rsp_pixel_value),
      .rsp_detection_count(rsp_detection_count),
      .rsp_bright_warning (rsp_bright_warning),
      .rsp_dark_warning   (rsp_dark_warning),
      .rsp_limit_reached  (rsp_limit_reached),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

>>> design/lmsd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lmsd_protocol_checker
   import lmsd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_record_kind,
   input wire logic [9:0]  rsp_pos_x,
   input wire logic [9:0]  rsp_pos_y,
   input wire logic [15:0] rsp_pixel_value,
   input wire logic        rsp_last,
   input wire logic        req_valid,
   input wire logic        req_stall
);

   // a stalled transaction keeps its record
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_record_kind) && $stable(rsp_last))
      else $error("result changed while stalled");

   // a summary always closes its pixel's results
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_kind == REC_SUMMARY |-> rsp_last)
      else $error("summary without last");

   // a summary carries no position or pixel
   a_summary_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_kind == REC_SUMMARY |->
         rsp_pos_x == 10'd0 && rsp_pos_y == 10'd0 && rsp_pixel_value == 16'd0)
      else $error("summary with stray payload");

   // a window pixel record that is not the last is followed by another record
   a_pixel_after_detect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_record_kind == REC_PIXEL && !rsp_last
         |=> rsp_valid)
      else $error("window copy broken up");

   // input is taken only while the front sequencer is free
   a_req_stall_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("two pixels taken back to back");

endmodule

bind local_maximum_spot_detector lmsd_protocol_checker u_checker (.*);

`default_nettype wire
